// ----- sv/elb_pkg.sv -----
// Shared types, constants and codes for the endpoint load balancer.
package elb_pkg;

    localparam int MAX_ENDPOINTS = 16;
    localparam int SLOT_W        = $clog2(MAX_ENDPOINTS);
    localparam int CNT_W         = $clog2(MAX_ENDPOINTS + 1);
    localparam int KEY_W         = 32;
    localparam int WT_W          = 16;
    localparam int CONN_W        = 16;
    localparam int SUM_W         = 20;
    localparam int DRAW_W        = 32;
    localparam int ACT_W         = 3;
    localparam int POL_W         = 3;
    localparam int IN_W          = 120;
    localparam int OUT_W         = 88;

    localparam logic [ACT_W-1:0] ACT_SELECT   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_HEALTH   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ADD      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CONN_END = 3'd4;

    localparam logic [POL_W-1:0] POL_RR   = 3'd0;
    localparam logic [POL_W-1:0] POL_LC   = 3'd1;
    localparam logic [POL_W-1:0] POL_WRR  = 3'd2;
    localparam logic [POL_W-1:0] POL_HASH = 3'd3;
    localparam logic [POL_W-1:0] POL_RAND = 3'd4;

    localparam logic [CONN_W-1:0] CONN_MAX = '1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [WT_W-1:0]   weight;
        logic              health;
        logic [CONN_W-1:0] conn;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [DRAW_W-1:0] random_draw;
        logic              client_present;
        logic [DRAW_W-1:0] client_hash;
        logic [WT_W-1:0]   weight;
        logic              healthy_flag;
        logic [KEY_W-1:0]  instance_key;
        logic [ACT_W-1:0]  action;
    } item_t;

    typedef struct packed {
        logic [SUM_W-1:0]  connection_total;
        logic [CNT_W-1:0]  healthy_total;
        logic [CNT_W-1:0]  entry_total;
        logic [WT_W-1:0]   selected_weight;
        logic [KEY_W-1:0]  selected_key;
        logic [SLOT_W-1:0] selected_slot;
        logic              ok;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN1,
        ST_DISP,
        ST_DIV,
        ST_SCAN2,
        ST_PICK_RD,
        ST_PICK_WB,
        ST_RM_RD,
        ST_RM_WB,
        ST_STATS,
        ST_DONE
    } state_t;

endpackage

// ----- sv/elb_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module elb_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 65
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- sv/elb_div.sv -----
// Iterative restoring divider producing the remainder, one bit per cycle.
module elb_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [elb_pkg::DRAW_W-1:0] dividend,
    input  logic [elb_pkg::SUM_W-1:0]  divisor,
    output logic                       done,
    output logic [elb_pkg::SUM_W-1:0]  rem
);

    localparam int CW = $clog2(elb_pkg::DRAW_W + 1);

    logic                       busy_reg;
    logic [CW-1:0]              cnt_reg;
    logic [elb_pkg::DRAW_W-1:0] q_reg;
    logic [elb_pkg::SUM_W-1:0]  d_reg;
    logic [elb_pkg::SUM_W:0]    r_reg;
    logic [elb_pkg::SUM_W:0]    r_shift;

    assign r_shift = {r_reg[elb_pkg::SUM_W-1:0], q_reg[elb_pkg::DRAW_W-1]};
    assign done    = busy_reg && (cnt_reg == CW'(0));
    assign rem     = r_reg[elb_pkg::SUM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(elb_pkg::DRAW_W);
            q_reg    <= dividend;
            d_reg    <= divisor;
            r_reg    <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == CW'(0)) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - CW'(1);
                q_reg   <= {q_reg[elb_pkg::DRAW_W-2:0], 1'b0};
                if (r_shift >= {1'b0, d_reg}) begin
                    r_reg <= r_shift - {1'b0, d_reg};
                end else begin
                    r_reg <= r_shift;
                end
            end
        end
    end

endmodule

// ----- sv/elb_core.sv -----
// Sequencer that scans, selects and updates the endpoint table held in RAM.
module elb_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  elb_pkg::item_t            in_item,
    input  logic [elb_pkg::POL_W-1:0] policy,
    output logic                      res_valid,
    input  logic                      res_ready,
    output elb_pkg::res_t             res
);

    localparam int SW = elb_pkg::SLOT_W;
    localparam int NW = elb_pkg::CNT_W;

    elb_pkg::state_t state_reg, state_next;
    elb_pkg::item_t  it_reg;
    elb_pkg::entry_t rd_data, wr_data, fent_reg, e;

    logic [NW-1:0] n_reg, idx_reg, hcnt_reg, hsum_reg;
    logic [SW-1:0] rotor_reg, pidx_reg, fslot_reg, lc_slot_reg, fh_slot_reg, rh_slot_reg;
    logic [SW-1:0] pick_reg, sslot_reg, rd_addr, wr_addr;
    logic          pend_reg, found_reg, fh_ok_reg, rh_ok_reg, picked_reg, ok_reg;
    logic [elb_pkg::SUM_W-1:0]  wtot_reg, tgt_reg, acc_reg, csum_reg, acc_sum;
    logic [elb_pkg::CONN_W:0]   best_reg;
    logic [elb_pkg::KEY_W-1:0]  skey_reg;
    logic [elb_pkg::WT_W-1:0]   swt_reg;
    logic [SW-1:0]              rr_pick;
    logic [NW-1:0]              n_less;

    logic scanning, issue, scan_end, we, div_start, div_done;
    logic [elb_pkg::DRAW_W-1:0] div_a;
    logic [elb_pkg::SUM_W-1:0]  div_b, div_rem;

    assign e        = rd_data;
    assign scanning = (state_reg == elb_pkg::ST_SCAN1) || (state_reg == elb_pkg::ST_SCAN2) ||
                      (state_reg == elb_pkg::ST_STATS);
    assign issue    = scanning && (idx_reg < n_reg);
    assign scan_end = scanning && !issue && !pend_reg;
    assign acc_sum  = acc_reg + elb_pkg::SUM_W'(e.weight);
    assign rr_pick  = rh_ok_reg ? rh_slot_reg : fh_slot_reg;
    assign n_less   = n_reg - NW'(1);

    elb_ram #(
        .DEPTH(elb_pkg::MAX_ENDPOINTS),
        .WIDTH(elb_pkg::ENTRY_W)
    ) u_ram (
        .aclk   (aclk),
        .we     (we),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    elb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_a),
        .divisor (div_b),
        .done    (div_done),
        .rem     (div_rem)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            elb_pkg::ST_IDLE: begin
                if (in_valid) state_next = elb_pkg::ST_SCAN1;
            end
            elb_pkg::ST_SCAN1: begin
                if (scan_end) state_next = elb_pkg::ST_DISP;
            end
            elb_pkg::ST_DISP: begin
                state_next = elb_pkg::ST_STATS;
                if (it_reg.action == elb_pkg::ACT_SELECT && hcnt_reg != NW'(0)) begin
                    case (policy)
                        elb_pkg::POL_RR, elb_pkg::POL_LC: state_next = elb_pkg::ST_PICK_RD;
                        elb_pkg::POL_WRR: begin
                            if (wtot_reg != '0) state_next = elb_pkg::ST_DIV;
                        end
                        elb_pkg::POL_HASH: begin
                            state_next = it_reg.client_present ? elb_pkg::ST_DIV
                                                               : elb_pkg::ST_SCAN2;
                        end
                        elb_pkg::POL_RAND: state_next = elb_pkg::ST_DIV;
                        default: state_next = elb_pkg::ST_STATS;
                    endcase
                end else if (it_reg.action == elb_pkg::ACT_REMOVE && found_reg &&
                             NW'(fslot_reg) < n_less) begin
                    state_next = elb_pkg::ST_RM_RD;
                end
            end
            elb_pkg::ST_DIV: begin
                if (div_done) state_next = elb_pkg::ST_SCAN2;
            end
            elb_pkg::ST_SCAN2: begin
                if (scan_end) state_next = elb_pkg::ST_PICK_RD;
            end
            elb_pkg::ST_PICK_RD: state_next = elb_pkg::ST_PICK_WB;
            elb_pkg::ST_PICK_WB: state_next = elb_pkg::ST_STATS;
            elb_pkg::ST_RM_RD:   state_next = elb_pkg::ST_RM_WB;
            elb_pkg::ST_RM_WB:   state_next = elb_pkg::ST_STATS;
            elb_pkg::ST_STATS: begin
                if (scan_end) state_next = elb_pkg::ST_DONE;
            end
            elb_pkg::ST_DONE: begin
                if (res_ready) state_next = elb_pkg::ST_IDLE;
            end
            default: state_next = elb_pkg::ST_IDLE;
        endcase
    end

    // outputs, RAM and divider controls
    always_comb begin
        in_ready  = (state_reg == elb_pkg::ST_IDLE);
        res_valid = (state_reg == elb_pkg::ST_DONE);
        rd_addr   = idx_reg[SW-1:0];
        we        = 1'b0;
        wr_addr   = fslot_reg;
        wr_data   = fent_reg;
        div_start = 1'b0;
        div_a     = it_reg.random_draw;
        div_b     = wtot_reg;
        case (state_reg)
            elb_pkg::ST_DISP: begin
                case (it_reg.action)
                    elb_pkg::ACT_SELECT: begin
                        div_start = (hcnt_reg != NW'(0)) &&
                                    ((policy == elb_pkg::POL_WRR && wtot_reg != '0) ||
                                     (policy == elb_pkg::POL_HASH && it_reg.client_present) ||
                                     policy == elb_pkg::POL_RAND);
                        if (policy == elb_pkg::POL_HASH) begin
                            div_a = it_reg.client_hash;
                            div_b = elb_pkg::SUM_W'(n_reg);
                        end else if (policy == elb_pkg::POL_RAND) begin
                            div_b = elb_pkg::SUM_W'(hcnt_reg);
                        end
                    end
                    elb_pkg::ACT_HEALTH: begin
                        we             = found_reg;
                        wr_data.health = it_reg.healthy_flag;
                        if (!it_reg.healthy_flag) wr_data.conn = '0;
                    end
                    elb_pkg::ACT_ADD: begin
                        wr_data.weight = it_reg.weight;
                        wr_data.health = it_reg.healthy_flag;
                        if (found_reg) begin
                            we = 1'b1;
                        end else begin
                            we           = (n_reg < NW'(elb_pkg::MAX_ENDPOINTS));
                            wr_addr      = n_reg[SW-1:0];
                            wr_data.key  = it_reg.instance_key;
                            wr_data.conn = '0;
                        end
                    end
                    elb_pkg::ACT_CONN_END: begin
                        we = found_reg && (policy == elb_pkg::POL_LC);
                        if (fent_reg.conn != '0) begin
                            wr_data.conn = fent_reg.conn - elb_pkg::CONN_W'(1);
                        end
                    end
                    default: we = 1'b0;
                endcase
            end
            elb_pkg::ST_PICK_RD: rd_addr = pick_reg;
            elb_pkg::ST_PICK_WB: begin
                we      = (policy == elb_pkg::POL_LC);
                wr_addr = pick_reg;
                wr_data = rd_data;
                if (rd_data.conn != elb_pkg::CONN_MAX) begin
                    wr_data.conn = rd_data.conn + elb_pkg::CONN_W'(1);
                end
            end
            elb_pkg::ST_RM_RD: rd_addr = n_reg[SW-1:0];
            elb_pkg::ST_RM_WB: begin
                we      = 1'b1;
                wr_data = rd_data;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= elb_pkg::ST_IDLE;
            n_reg     <= '0;
            rotor_reg <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (state_next != state_reg) begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end else if (issue) begin
                idx_reg  <= idx_reg + NW'(1);
                pend_reg <= 1'b1;
                pidx_reg <= idx_reg[SW-1:0];
            end else begin
                pend_reg <= 1'b0;
            end

            if (state_next == elb_pkg::ST_STATS && state_reg != elb_pkg::ST_STATS) begin
                hsum_reg <= '0;
                csum_reg <= '0;
            end

            case (state_reg)
                elb_pkg::ST_IDLE: begin
                    if (in_valid) begin
                        it_reg    <= in_item;
                        found_reg <= 1'b0;
                        hcnt_reg  <= '0;
                        wtot_reg  <= '0;
                        best_reg  <= {1'b1, {elb_pkg::CONN_W{1'b0}}};
                        fh_ok_reg <= 1'b0;
                        rh_ok_reg <= 1'b0;
                        ok_reg    <= 1'b0;
                        sslot_reg <= '0;
                        skey_reg  <= '0;
                        swt_reg   <= '0;
                    end
                end
                elb_pkg::ST_SCAN1: begin
                    if (pend_reg) begin
                        if (e.key == it_reg.instance_key && !found_reg) begin
                            found_reg <= 1'b1;
                            fslot_reg <= pidx_reg;
                            fent_reg  <= e;
                        end
                        if (e.health) begin
                            hcnt_reg <= hcnt_reg + NW'(1);
                            wtot_reg <= wtot_reg + elb_pkg::SUM_W'(e.weight);
                            if ({1'b0, e.conn} < best_reg) begin
                                best_reg    <= {1'b0, e.conn};
                                lc_slot_reg <= pidx_reg;
                            end
                            if (!fh_ok_reg) begin
                                fh_ok_reg   <= 1'b1;
                                fh_slot_reg <= pidx_reg;
                            end
                            if (!rh_ok_reg && pidx_reg > rotor_reg) begin
                                rh_ok_reg   <= 1'b1;
                                rh_slot_reg <= pidx_reg;
                            end
                        end
                    end
                end
                elb_pkg::ST_DISP: begin
                    picked_reg <= 1'b0;
                    acc_reg    <= '0;
                    tgt_reg    <= '0;
                    case (it_reg.action)
                        elb_pkg::ACT_SELECT: begin
                            if (policy == elb_pkg::POL_RR) begin
                                pick_reg <= rr_pick;
                                if (hcnt_reg != NW'(0)) rotor_reg <= rr_pick;
                            end else begin
                                pick_reg <= lc_slot_reg;
                            end
                        end
                        elb_pkg::ACT_HEALTH: ok_reg <= found_reg;
                        elb_pkg::ACT_ADD: begin
                            if (found_reg) begin
                                ok_reg <= 1'b1;
                            end else if (n_reg < NW'(elb_pkg::MAX_ENDPOINTS)) begin
                                ok_reg <= 1'b1;
                                n_reg  <= n_reg + NW'(1);
                            end
                        end
                        elb_pkg::ACT_REMOVE: begin
                            if (found_reg) begin
                                ok_reg <= 1'b1;
                                n_reg  <= n_less;
                                if (NW'(rotor_reg) >= n_less && n_less != NW'(0)) begin
                                    rotor_reg <= '0;
                                end
                            end
                        end
                        elb_pkg::ACT_CONN_END: ok_reg <= found_reg && (policy == elb_pkg::POL_LC);
                        default: ok_reg <= 1'b0;
                    endcase
                end
                elb_pkg::ST_DIV: begin
                    if (div_done) tgt_reg <= div_rem;
                end
                elb_pkg::ST_SCAN2: begin
                    if (pend_reg && e.health && !picked_reg) begin
                        case (policy)
                            elb_pkg::POL_WRR: begin
                                acc_reg <= acc_sum;
                                if (tgt_reg < acc_sum) begin
                                    picked_reg <= 1'b1;
                                    pick_reg   <= pidx_reg;
                                end
                            end
                            elb_pkg::POL_HASH: begin
                                if (elb_pkg::SUM_W'(pidx_reg) >= tgt_reg) begin
                                    picked_reg <= 1'b1;
                                    pick_reg   <= pidx_reg;
                                end
                            end
                            default: begin
                                if (tgt_reg == '0) begin
                                    picked_reg <= 1'b1;
                                    pick_reg   <= pidx_reg;
                                end else begin
                                    tgt_reg <= tgt_reg - elb_pkg::SUM_W'(1);
                                end
                            end
                        endcase
                    end
                    if (scan_end && !picked_reg) pick_reg <= fh_slot_reg;
                end
                elb_pkg::ST_PICK_WB: begin
                    ok_reg    <= 1'b1;
                    sslot_reg <= pick_reg;
                    skey_reg  <= rd_data.key;
                    swt_reg   <= rd_data.weight;
                end
                elb_pkg::ST_STATS: begin
                    if (pend_reg) begin
                        hsum_reg <= hsum_reg + NW'(e.health);
                        csum_reg <= csum_reg + elb_pkg::SUM_W'(e.conn);
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        res.ok               = ok_reg;
        res.selected_slot    = sslot_reg;
        res.selected_key     = skey_reg;
        res.selected_weight  = swt_reg;
        res.entry_total      = n_reg;
        res.healthy_total    = hsum_reg;
        res.connection_total = (policy == elb_pkg::POL_LC) ? csum_reg : '0;
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= NW'(elb_pkg::MAX_ENDPOINTS))
        else $error("entry count above table size");

    a_write_state: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> (state_reg == elb_pkg::ST_DISP || state_reg == elb_pkg::ST_PICK_WB ||
                state_reg == elb_pkg::ST_RM_WB))
        else $error("table write outside an update step");

    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == elb_pkg::ST_SCAN1))
        else $error("accepted word did not start a scan");

    a_sel_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && ok_reg && it_reg.action == elb_pkg::ACT_SELECT) |->
        (NW'(sslot_reg) < n_reg))
        else $error("selected slot beyond table");

endmodule

// ----- sv/endpoint_load_balancer.sv -----
// Top level of the endpoint load balancer: ports, policy register, result register.
//
// channel  direction  handshake                  payload
// s_       in         s_tvalid / s_tready        s_tdata  request word
// m_       out        m_tvalid / m_tready        m_tdata  result word
// cfg_     in         cfg_valid / cfg_ready      cfg_data policy
//
// One request at a time, one RAM read per entry in each table scan. A request runs a
// first scan, a dispatch step and a stats scan; a moving remove adds a read and write,
// a select a pick read and write-back, and weighted, hashed or random picks a second
// scan before it, after a remainder division unless hashing lacks client data.
// Reset is synchronous, active low, clears the table count, rotor and policy.
// A stalled result waits in the output register while the next request runs.
module endpoint_load_balancer (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // action, instance_key, healthy_flag, weight, client_hash, client_present,
    // random_draw, zero pad
    input  logic [elb_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // ok, selected_slot, selected_key, selected_weight, entry_total,
    // healthy_total, connection_total, zero pad
    output logic [elb_pkg::OUT_W-1:0] m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [elb_pkg::POL_W-1:0] cfg_data
);

    logic [elb_pkg::POL_W-1:0] policy_reg;
    logic                      m_tvalid_reg;
    elb_pkg::res_t             res, res_reg;
    elb_pkg::item_t            item;
    logic                      res_valid, res_ready;

    assign cfg_ready = 1'b1;
    assign item      = s_tdata[$bits(elb_pkg::item_t)-1:0];
    assign res_ready = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(elb_pkg::OUT_W - $bits(elb_pkg::res_t)){1'b0}}, res_reg};

    elb_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (item),
        .policy   (policy_reg),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg   <= elb_pkg::POL_RR;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) policy_reg <= cfg_data;
            if (res_ready) begin
                m_tvalid_reg <= res_valid;
                if (res_valid) res_reg <= res;
            end
        end
    end

endmodule

// ----- tb/elb_checker.sv -----
// Checker for the endpoint load balancer: predicts each result word and compares it.
`timescale 1ns / 1ps
module elb_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [elb_pkg::IN_W-1:0]  s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [elb_pkg::OUT_W-1:0] m_tdata,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [elb_pkg::POL_W-1:0] cfg_data,
    output int                        fail_count,
    output int                        pending
);

    logic [elb_pkg::KEY_W-1:0]  keys [elb_pkg::MAX_ENDPOINTS];
    logic [elb_pkg::WT_W-1:0]   wts  [elb_pkg::MAX_ENDPOINTS];
    logic                       hlth [elb_pkg::MAX_ENDPOINTS];
    logic [elb_pkg::CONN_W-1:0] conns[elb_pkg::MAX_ENDPOINTS];
    int                         n_entries;
    int                         rotor;
    logic [elb_pkg::POL_W-1:0]  pol;
    elb_pkg::res_t              expected_results[$];

    assign pending = expected_results.size();

    function automatic int find_slot(logic [elb_pkg::KEY_W-1:0] k);
        for (int i = 0; i < n_entries; i++)
            if (keys[i] == k) return i;
        return -1;
    endfunction

    function automatic int pick_endpoint(elb_pkg::item_t it);
        int healthy;
        longint total;
        longint acc;
        longint target;
        int start;
        int best;
        int pick;
        int s;
        healthy = 0;
        pick = -1;
        for (int i = 0; i < n_entries; i++) healthy += hlth[i];
        if (healthy == 0) return -1;
        case (pol)
            elb_pkg::POL_RR: begin
                for (int i = 0; i < n_entries; i++) begin
                    rotor = (rotor + 1) % n_entries;
                    if (hlth[rotor]) return rotor;
                end
            end
            elb_pkg::POL_LC: begin
                best = 32'h10000;
                for (int i = 0; i < n_entries; i++)
                    if (hlth[i] && conns[i] < best) begin
                        best = conns[i];
                        pick = i;
                    end
                if (pick >= 0 && conns[pick] != elb_pkg::CONN_MAX) conns[pick]++;
                return pick;
            end
            elb_pkg::POL_WRR: begin
                total = 0;
                acc = 0;
                for (int i = 0; i < n_entries; i++) if (hlth[i]) total += wts[i];
                if (total == 0) return -1;
                target = longint'(it.random_draw) % total;
                for (int i = 0; i < n_entries; i++)
                    if (hlth[i]) begin
                        acc += wts[i];
                        if (target < acc) return i;
                    end
            end
            elb_pkg::POL_HASH: begin
                start = it.client_present ? int'(longint'(it.client_hash) % n_entries) : 0;
                for (int i = 0; i < n_entries; i++) begin
                    s = (start + i) % n_entries;
                    if (hlth[s]) return s;
                end
            end
            elb_pkg::POL_RAND: begin
                target = longint'(it.random_draw) % healthy;
                for (int i = 0; i < n_entries; i++)
                    if (hlth[i]) begin
                        if (target == 0) return i;
                        target--;
                    end
            end
            default: return -1;
        endcase
        return -1;
    endfunction

    function automatic elb_pkg::res_t apply_request(elb_pkg::item_t it);
        elb_pkg::res_t r;
        int s;
        int last;
        int h;
        int c;
        r = '0;
        case (it.action)
            elb_pkg::ACT_SELECT: begin
                s = pick_endpoint(it);
                if (s >= 0) begin
                    r.ok = 1'b1;
                    r.selected_slot = elb_pkg::SLOT_W'(s);
                    r.selected_key = keys[s];
                    r.selected_weight = wts[s];
                end
            end
            elb_pkg::ACT_HEALTH: begin
                s = find_slot(it.instance_key);
                if (s >= 0) begin
                    hlth[s] = it.healthy_flag;
                    if (!it.healthy_flag) conns[s] = '0;
                    r.ok = 1'b1;
                end
            end
            elb_pkg::ACT_ADD: begin
                s = find_slot(it.instance_key);
                if (s >= 0) begin
                    wts[s] = it.weight;
                    hlth[s] = it.healthy_flag;
                    r.ok = 1'b1;
                end else if (n_entries < elb_pkg::MAX_ENDPOINTS) begin
                    keys[n_entries] = it.instance_key;
                    wts[n_entries] = it.weight;
                    hlth[n_entries] = it.healthy_flag;
                    conns[n_entries] = '0;
                    n_entries++;
                    r.ok = 1'b1;
                end
            end
            elb_pkg::ACT_REMOVE: begin
                s = find_slot(it.instance_key);
                if (s >= 0) begin
                    last = n_entries - 1;
                    if (s < last) begin
                        keys[s] = keys[last];
                        wts[s] = wts[last];
                        hlth[s] = hlth[last];
                        conns[s] = conns[last];
                    end
                    n_entries = last;
                    if (rotor >= n_entries && n_entries > 0) rotor = 0;
                    r.ok = 1'b1;
                end
            end
            elb_pkg::ACT_CONN_END: begin
                if (pol == elb_pkg::POL_LC) begin
                    s = find_slot(it.instance_key);
                    if (s >= 0) begin
                        if (conns[s] != 0) conns[s]--;
                        r.ok = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        h = 0;
        c = 0;
        for (int i = 0; i < n_entries; i++) begin
            h += hlth[i];
            c += conns[i];
        end
        r.entry_total = elb_pkg::CNT_W'(n_entries);
        r.healthy_total = elb_pkg::CNT_W'(h);
        r.connection_total = (pol == elb_pkg::POL_LC) ? elb_pkg::SUM_W'(c) : '0;
        return r;
    endfunction

    always @(posedge aclk) begin
        elb_pkg::res_t got;
        elb_pkg::res_t exp_r;
        if (!aresetn) begin
            n_entries = 0;
            rotor = 0;
            pol = elb_pkg::POL_RR;
            fail_count = 0;
            for (int i = 0; i < elb_pkg::MAX_ENDPOINTS; i++) conns[i] = '0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) pol = cfg_data;
            if (s_tvalid && s_tready)
                expected_results.push_back(
                    apply_request(s_tdata[$bits(elb_pkg::item_t)-1:0]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(elb_pkg::res_t)-1:0];
                if (expected_results.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result word %h", got);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        if (fail_count < 10)
                            $display("result mismatch: expected %h, got %h", exp_r, got);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ----- tb/tb_endpoint_load_balancer.sv -----
// Testbench top for the endpoint load balancer: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_endpoint_load_balancer;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [elb_pkg::IN_W-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [elb_pkg::OUT_W-1:0] m_tdata;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [elb_pkg::POL_W-1:0] cfg_data = '0;
    int                        fail_count;
    int                        pending;
    longint                    cycle = 0;
    logic [elb_pkg::KEY_W-1:0] key_pool[8];

    localparam longint CYCLE_LIMIT = 2_000_000;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    endpoint_load_balancer u_dut (.*);

    elb_checker u_chk (.*);

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver stall pattern: stretches of always-ready and random stalls
    always @(posedge aclk) begin
        if (((cycle >> 9) & 3) == 0) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_word(elb_pkg::item_t it);
        s_tvalid <= 1'b1;
        s_tdata <= elb_pkg::IN_W'(it);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic idle_gap();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    task automatic set_policy(logic [elb_pkg::POL_W-1:0] p);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= p;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic elb_pkg::item_t make_word(logic [elb_pkg::ACT_W-1:0] act,
                                                 logic [elb_pkg::KEY_W-1:0] k,
                                                 logic h, logic [elb_pkg::WT_W-1:0] w);
        elb_pkg::item_t it;
        it.action = act;
        it.instance_key = k;
        it.healthy_flag = h;
        it.weight = w;
        it.client_hash = $urandom();
        it.client_present = 1'($urandom_range(0, 1));
        it.random_draw = $urandom();
        return it;
    endfunction

    function automatic elb_pkg::item_t random_word();
        int r;
        logic [elb_pkg::KEY_W-1:0] k;
        logic [elb_pkg::WT_W-1:0] w;
        r = $urandom_range(0, 99);
        k = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
        case ($urandom_range(0, 3))
            0: w = 16'hFFFF;
            1: w = elb_pkg::WT_W'($urandom_range(0, 3));
            default: w = elb_pkg::WT_W'($urandom());
        endcase
        if (r < 40) return make_word(elb_pkg::ACT_SELECT, k, 1'b1, w);
        if (r < 58) return make_word(elb_pkg::ACT_ADD, k, ($urandom_range(0, 4) != 0), w);
        if (r < 70) return make_word(elb_pkg::ACT_HEALTH, k, 1'($urandom_range(0, 1)), w);
        if (r < 80) return make_word(elb_pkg::ACT_REMOVE, k, 1'($urandom_range(0, 1)), w);
        if (r < 95) return make_word(elb_pkg::ACT_CONN_END, k, 1'($urandom_range(0, 1)), w);
        return make_word(elb_pkg::ACT_W'($urandom_range(5, 7)), k, 1'b1, w);
    endfunction

    initial begin
        elb_pkg::item_t it;
        logic [elb_pkg::POL_W-1:0] pols[10];
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;
        pols = '{elb_pkg::POL_RR, elb_pkg::POL_LC, elb_pkg::POL_WRR, elb_pkg::POL_HASH,
                 elb_pkg::POL_RAND, 3'd7, elb_pkg::POL_LC, 3'd5, elb_pkg::POL_WRR,
                 elb_pkg::POL_RR};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, fill past full, each action, extremes
        send_word(make_word(elb_pkg::ACT_SELECT, '0, 1'b1, '0));
        send_word(make_word(elb_pkg::ACT_REMOVE, '1, 1'b0, '0));
        for (int i = 0; i < 17; i++)
            send_word(make_word(elb_pkg::ACT_ADD,
                                (i < 2) ? key_pool[i] : elb_pkg::KEY_W'(32'h100 + i),
                                i != 3, (i == 0) ? 16'hFFFF : elb_pkg::WT_W'(i)));
        send_word(make_word(elb_pkg::ACT_ADD, '1, 1'b1, 16'h0));
        send_word(make_word(elb_pkg::ACT_HEALTH, key_pool[0], 1'b0, '0));
        send_word(make_word(elb_pkg::ACT_SELECT, '0, 1'b1, '0));
        send_word(make_word(elb_pkg::ACT_REMOVE, 32'h102, 1'b0, '0));
        send_word(make_word(elb_pkg::ACT_CONN_END, '1, 1'b0, '0));
        send_word(make_word(3'd7, '1, 1'b1, '1));

        for (int ph = 0; ph < 10; ph++) begin
            set_policy(pols[ph]);
            for (int n = 0; n < 130; n++) begin
                it = random_word();
                if (ph == 1 && n < 20) it = make_word(elb_pkg::ACT_SELECT, '0, 1'b1, '0);
                send_word(it);
                if ($urandom_range(0, 4) == 0) idle_gap();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/elb_pkg.sv
sv/elb_ram.sv
sv/elb_div.sv
sv/elb_core.sv
sv/endpoint_load_balancer.sv
tb/elb_checker.sv
tb/tb_endpoint_load_balancer.sv
